/* sv/rational_arith_unit_macros.svh */
// Assertion helpers used by rational_arith_unit.
`ifndef RATIONAL_ARITH_UNIT_MACROS_SVH
`define RATIONAL_ARITH_UNIT_MACROS_SVH

// Checked only outside reset.
`define RAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define RAU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/rau_pkg.sv */
`default_nettype none

package rau_pkg;

  localparam int RAU_WIDTH = 32;

  localparam logic [2:0] FUNC_ADD = 3'd0;
  localparam logic [2:0] FUNC_SUB = 3'd1;
  localparam logic [2:0] FUNC_MUL = 3'd2;
  localparam logic [2:0] FUNC_DIV = 3'd3;
  localparam logic [2:0] FUNC_RED = 3'd4;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic               less;
    logic               equal;
    logic               zero_den;
    logic               overflow;
  } rau_out_t;

  typedef struct packed {
    logic busy;
    logic done;
  } rau_div_stat_t;

endpackage

`default_nettype wire

/* sv/rau_div.sv */
`default_nettype none

module rau_div #(
  parameter int W = 2 * rau_pkg::RAU_WIDTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [W-1:0]          dividend,
  input  wire logic [W-1:0]          divisor,
  output logic [W-1:0]               quotient,
  output logic [W-1:0]               remainder,
  output rau_pkg::rau_div_stat_t     stat
);
  import rau_pkg::*;

  localparam int CW = $clog2(W);

  logic [W-1:0]  quo;
  logic [W-1:0]  rem;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [W:0]    sh;
  logic [W:0]    diff;
  logic          ge;

  // restoring radix-2, one quotient bit per cycle
  assign sh   = {rem, quo[W-1]};
  assign ge   = sh >= {1'b0, dsr};
  assign diff = sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
      cnt <= CW'(W - 1);
    end else if (busy) begin
      quo <= {quo[W-2:0], ge};
      rem <= ge ? diff[W-1:0] : sh[W-1:0];
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

endmodule

`default_nettype wire

/* sv/rational_arith_unit.sv */
// Channel | Dir | Handshake          | Payload
// req     | in  | req_valid/req_stall | rau_in_t: func, a_num, a_den, b_num, b_den
// rsp     | out | rsp_valid/rsp_stall | rau_out_t: res_num, res_den, flags
//
// One transaction at a time; req_stall is high from acceptance until the result
// is loaded. Every Euclid remainder and both final quotients go through the one
// radix-2 divider, one bit per cycle. Four products share one multiplier.
// rst is synchronous; it clears the sequencer and rsp_valid. A stalled result
// waits in the output register while the next transaction is taken and worked on.
`default_nettype none

module rational_arith_unit #(
  parameter int WIDTH = rau_pkg::RAU_WIDTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  input  wire rau_pkg::rau_in_t req,
  output logic                  rsp_valid,
  input  wire logic             rsp_stall,
  output rau_pkg::rau_out_t     rsp
);
  import rau_pkg::*;

  `include "rational_arith_unit_macros.svh"

  localparam int MW = 2 * WIDTH;

  typedef enum logic [10:0] {
    S_IDLE     = 11'b00000000001,
    S_MUL      = 11'b00000000010,
    S_FORM     = 11'b00000000100,
    S_ABS      = 11'b00000001000,
    S_CHECK    = 11'b00000010000,
    S_EUC      = 11'b00000100000,
    S_EUC_WAIT = 11'b00001000000,
    S_QN_WAIT  = 11'b00010000000,
    S_QD_START = 11'b00100000000,
    S_QD_WAIT  = 11'b01000000000,
    S_OUT      = 11'b10000000000
  } state_t;

  state_t state;

  logic [2:0]              op;
  logic signed [WIDTH-1:0] an, ad, bn, bd;
  logic                    eq;
  logic                    lt;
  logic [1:0]              mstep;
  logic signed [MW-1:0]    prod [4];
  logic signed [MW:0]      num_raw;
  logic signed [MW-1:0]    den_raw;
  logic                    nn, dn;
  logic [MW-1:0]           nm, dm;
  logic [MW-1:0]           u, v;
  logic                    k_odd;
  logic [MW-1:0]           qnm, qdm;
  logic                    zd;

  logic signed [WIDTH-1:0] ma, mb;
  logic signed [MW:0]      t1, t2;

  logic                    div_start;
  logic [MW-1:0]           div_dividend, div_divisor;
  logic [MW-1:0]           div_quo, div_rem;
  rau_div_stat_t           div_stat;

  logic                    gn, qnn, qdn;
  logic [MW-1:0]           sn, sd, lim;
  logic signed [WIDTH-1:0] lo_n, lo_d;
  logic                    fit_n, fit_d;
  logic                    out_load;

  always_comb begin
    case (mstep)
      2'd0:    begin ma = an; mb = bd; end
      2'd1:    begin ma = bn; mb = ad; end
      2'd2:    begin ma = ad; mb = bd; end
      default: begin ma = an; mb = bn; end
    endcase
  end

  assign t1 = (MW + 1)'(prod[0]);
  assign t2 = (MW + 1)'(prod[1]);

  assign div_start    = (state == S_EUC) || (state == S_QD_START);
  assign div_dividend = (state == S_QD_START) ? dm : ((v != '0) ? u : nm);
  assign div_divisor  = (state == S_QD_START) ? u : ((v != '0) ? v : u);

  rau_div #(.W(MW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  assign gn    = k_odd ? dn : nn;
  assign qnn   = (qnm != '0) && (nn != gn);
  assign qdn   = (qdm != '0) && (dn != gn);
  assign sn    = qnn ? -qnm : qnm;
  assign sd    = qdn ? -qdm : qdm;
  assign lo_n  = sn[WIDTH-1:0];
  assign lo_d  = sd[WIDTH-1:0];
  assign lim   = MW'(1) << (WIDTH - 1);
  assign fit_n = qnn ? (qnm <= lim) : (qnm < lim);
  assign fit_d = qdn ? (qdm <= lim) : (qdm < lim);

  assign out_load  = (state == S_OUT) && (!rsp_valid || !rsp_stall);
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (mstep == 2'd3) begin
            state <= S_FORM;
          end
        end
        S_FORM:  state <= S_ABS;
        S_ABS:   state <= S_CHECK;
        S_CHECK: state <= (dm == '0) ? S_OUT : S_EUC;
        S_EUC:   state <= (v != '0) ? S_EUC_WAIT : S_QN_WAIT;
        S_EUC_WAIT: begin
          if (div_stat.done) begin
            state <= S_EUC;
          end
        end
        S_QN_WAIT: begin
          if (div_stat.done) begin
            state <= S_QD_START;
          end
        end
        S_QD_START: state <= S_QD_WAIT;
        S_QD_WAIT: begin
          if (div_stat.done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        op    <= req.func;
        an    <= req.a_num[WIDTH-1:0];
        ad    <= req.a_den[WIDTH-1:0];
        bn    <= req.b_num[WIDTH-1:0];
        bd    <= req.b_den[WIDTH-1:0];
        eq    <= (req.a_num[WIDTH-1:0] == req.b_num[WIDTH-1:0]) &&
                 (req.a_den[WIDTH-1:0] == req.b_den[WIDTH-1:0]);
        mstep <= 2'd0;
      end
      S_MUL: begin
        prod[mstep] <= MW'(ma) * MW'(mb);
        mstep       <= mstep + 2'd1;
      end
      S_FORM: begin
        lt <= prod[0] < prod[1];
        case (op)
          FUNC_ADD: begin num_raw <= t1 + t2; den_raw <= prod[2]; end
          FUNC_SUB: begin num_raw <= t1 - t2; den_raw <= prod[2]; end
          FUNC_MUL: begin num_raw <= (MW + 1)'(prod[3]); den_raw <= prod[2]; end
          FUNC_DIV: begin num_raw <= t1; den_raw <= prod[1]; end
          default: begin
            // reduce a; undefined codes land here too
            num_raw <= (MW + 1)'(an);
            den_raw <= MW'(ad);
          end
        endcase
      end
      S_ABS: begin
        nn <= num_raw < 0;
        nm <= (num_raw < 0) ? MW'(-num_raw) : MW'(num_raw);
        dn <= den_raw < 0;
        dm <= (den_raw < 0) ? MW'(-den_raw) : MW'(den_raw);
      end
      S_CHECK: begin
        u     <= nm;
        v     <= dm;
        k_odd <= 1'b0;
        zd    <= (dm == '0);
        qnm   <= '0;
        qdm   <= '0;
      end
      S_EUC_WAIT: begin
        if (div_stat.done) begin
          u     <= v;
          v     <= div_rem;
          k_odd <= ~k_odd;
        end
      end
      S_QN_WAIT: begin
        if (div_stat.done) begin
          qnm <= div_quo;
        end
      end
      S_QD_WAIT: begin
        if (div_stat.done) begin
          qdm <= div_quo;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.res_num  <= 32'(lo_n);
      rsp.res_den  <= 32'(lo_d);
      rsp.less     <= lt;
      rsp.equal    <= eq;
      rsp.zero_den <= zd;
      rsp.overflow <= !(fit_n && fit_d);
    end
  end

  `RAU_ASSERT(a_div_start_free, div_start |-> !div_stat.busy, "divider restarted while busy")
  `RAU_ASSERT(a_div_nonzero, div_start |-> (div_divisor != '0), "divide by zero issued")
  `RAU_ASSERT(a_div_done_after_busy, div_stat.done |-> $past(div_stat.busy), "spurious divider done")
  `RAU_ASSERT_ALWAYS(a_reset_idle, rst |=> (!rsp_valid && !req_stall), "not idle after reset")

endmodule

`default_nettype wire

/* sim/rational_checker.sv */
`timescale 1ns / 1ps

module rational_checker
  import rau_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  input  wire logic     req_stall,
  input  wire rau_in_t  req,
  input  wire logic     rsp_valid,
  input  wire logic     rsp_stall,
  input  wire rau_out_t rsp,
  output int            errors,
  output int            pending,
  output int            checked,
  output int            zero_dens,
  output int            overflows
);

  localparam int W = RAU_WIDTH;
  localparam logic [63:0] WMASK = (64'd1 << W) - 64'd1;

  rau_out_t reduced_q[$];

  function automatic longint sext_w(logic [31:0] v);
    logic [63:0] x;
    x = 64'(v) & WMASK;
    if (x[W-1]) x = x | ~WMASK;
    return $signed(x);
  endfunction

  function automatic void split(input longint p, output bit neg, output logic [63:0] mag);
    neg = p < 0;
    mag = neg ? 64'd0 - 64'(p) : 64'(p);
  endfunction

  function automatic void sm_sum(input bit n1, input logic [63:0] m1,
                                 input bit n2, input logic [63:0] m2,
                                 output bit neg, output logic [63:0] mag);
    if (n1 == n2) begin
      mag = m1 + m2;
      neg = n1;
    end else if (m1 >= m2) begin
      mag = m1 - m2;
      neg = n1;
    end else begin
      mag = m2 - m1;
      neg = n2;
    end
    if (mag == 0) neg = 1'b0;
  endfunction

  function automatic logic [31:0] to_field(bit neg, logic [63:0] mag);
    logic [63:0] r;
    r = (neg ? 64'd0 - mag : mag) & WMASK;
    if (r[W-1]) r = r | ~WMASK;
    return r[31:0];
  endfunction

  function automatic bit fits_w(bit neg, logic [63:0] mag);
    logic [63:0] lim;
    lim = 64'd1 << (W - 1);
    return neg ? (mag <= lim) : (mag < lim);
  endfunction

  function automatic rau_out_t reduce_result(rau_in_t t);
    longint an, ad, bn, bd;
    bit nn, dn, n1, n2, gn, qnn, qdn;
    logic [63:0] nm, dm, m1, m2, u, v, r, qn, qd;
    int k;
    rau_out_t o;
    an = sext_w(t.a_num);
    ad = sext_w(t.a_den);
    bn = sext_w(t.b_num);
    bd = sext_w(t.b_den);
    case (t.func)
      FUNC_ADD, FUNC_SUB: begin
        split(an * bd, n1, m1);
        split(bn * ad, n2, m2);
        if (t.func == FUNC_SUB && m2 != 0) n2 = !n2;
        sm_sum(n1, m1, n2, m2, nn, nm);
        split(ad * bd, dn, dm);
      end
      FUNC_MUL: begin
        split(an * bn, nn, nm);
        split(ad * bd, dn, dm);
      end
      FUNC_DIV: begin
        split(an * bd, nn, nm);
        split(ad * bn, dn, dm);
      end
      default: begin
        split(an, nn, nm);
        split(ad, dn, dm);
      end
    endcase
    o = '0;
    o.less  = (an * bd) < (bn * ad);
    o.equal = (an == bn) && (ad == bd);
    if (dm == 0) begin
      o.zero_den = 1'b1;
      return o;
    end
    // Euclid on magnitudes; parity of the step count picks the divisor's sign
    u = nm;
    v = dm;
    k = 0;
    while (v != 0) begin
      r = u % v;
      u = v;
      v = r;
      k++;
    end
    gn  = k[0] ? dn : nn;
    qn  = nm / u;
    qd  = dm / u;
    qnn = (qn != 0) && (nn != gn);
    qdn = (qd != 0) && (dn != gn);
    o.res_num  = to_field(qnn, qn);
    o.res_den  = to_field(qdn, qd);
    o.overflow = !(fits_w(qnn, qn) && fits_w(qdn, qd));
    return o;
  endfunction

  task automatic check_field(string name, logic signed [31:0] e, logic signed [31:0] a);
    if (e !== a) begin
      if (errors < 40)
        $display("%0t: %s mismatch, expected %0d (0x%h), got %0d (0x%h)",
                 $time, name, e, e, a, a);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    rau_out_t exp_r;
    if (rst) begin
      reduced_q.delete();
      errors    = 0;
      pending   = 0;
      checked   = 0;
      zero_dens = 0;
      overflows = 0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (reduced_q.size() == 0) begin
          if (errors < 40)
            $display("%0t: result with no transaction outstanding, num %0d den %0d",
                     $time, rsp.res_num, rsp.res_den);
          errors++;
        end else begin
          exp_r = reduced_q.pop_front();
          check_field("res_num", exp_r.res_num, rsp.res_num);
          check_field("res_den", exp_r.res_den, rsp.res_den);
          check_field("less", exp_r.less, rsp.less);
          check_field("equal", exp_r.equal, rsp.equal);
          check_field("zero_den", exp_r.zero_den, rsp.zero_den);
          check_field("overflow", exp_r.overflow, rsp.overflow);
          checked++;
          if (exp_r.zero_den) zero_dens++;
          if (exp_r.overflow) overflows++;
        end
      end
      if (req_valid && !req_stall) reduced_q.push_back(reduce_result(req));
      pending = reduced_q.size();
    end
  end

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import rau_pkg::*;

  localparam logic [2:0]  FUNC_RSV5 = 3'd5;
  localparam logic [2:0]  FUNC_RSV6 = 3'd6;
  localparam logic [2:0]  FUNC_RSV7 = 3'd7;
  localparam logic [31:0] MAXP = 32'h7fff_ffff;
  localparam logic [31:0] MINN = 32'h8000_0000;
  localparam logic [31:0] FIB46 = 32'd1836311903;
  localparam logic [31:0] FIB45 = 32'd1134903170;
  localparam int HOLD_CYCLES = 3000;
  localparam int WATCHDOG_LIMIT = 60000;

  logic     clk = 1'b0;
  logic     rst;
  logic     req_valid;
  logic     req_stall;
  rau_in_t  req;
  logic     rsp_valid;
  logic     rsp_stall;
  rau_out_t rsp;

  int errors, pending, checked, zero_dens, overflows;
  int send_idle_pct, stall_pct, hold_requests, sent;

  always #1 clk = ~clk;

  rational_arith_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  rational_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .errors    (errors),
    .pending   (pending),
    .checked   (checked),
    .zero_dens (zero_dens),
    .overflows (overflows)
  );

  function automatic logic [31:0] pick_operand();
    int sel;
    int w;
    logic [31:0] v;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(4))
        0: v = 32'd0;
        1: v = 32'd1;
        2: v = '1;
        3: v = MAXP;
        default: v = MINN;
      endcase
    end else begin
      if (sel < 50) v = $urandom_range(12);
      else if (sel < 92) begin
        w = $urandom_range(20, 2);
        v = $urandom & ((32'd1 << w) - 32'd1);
      end else v = $urandom;
      if ($urandom_range(1)) v = -v;
    end
    return v;
  endfunction

  function automatic rau_in_t random_item();
    rau_in_t t;
    if ($urandom_range(99) < 8) t.func = 3'($urandom_range(FUNC_RSV7, FUNC_RSV5));
    else t.func = 3'($urandom_range(FUNC_RED, FUNC_ADD));
    t.a_num = pick_operand();
    t.a_den = pick_operand();
    if ($urandom_range(99) < 5) begin
      t.b_num = t.a_num;
      t.b_den = t.a_den;
    end else begin
      t.b_num = pick_operand();
      t.b_den = pick_operand();
    end
    return t;
  endfunction

  // short Euclid chains, so the block turns results over quickly
  function automatic rau_in_t quick_item();
    rau_in_t t;
    t.func  = 3'($urandom_range(FUNC_RED, FUNC_ADD));
    t.a_num = $signed($urandom_range(80)) - 40;
    t.a_den = $signed($urandom_range(80)) - 40;
    t.b_num = $signed($urandom_range(80)) - 40;
    t.b_den = $signed($urandom_range(80)) - 40;
    return t;
  endfunction

  task automatic send_txn(input rau_in_t item);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req       <= item;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
    @(negedge clk);
  endtask

  task automatic directed(logic [2:0] f, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
    rau_in_t t;
    t = '{func: f, a_num: an, a_den: ad, b_num: bn, b_den: bd};
    send_txn(t);
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_random(int n, int send_pct, int rsp_pct);
    send_idle_pct = send_pct;
    stall_pct     = rsp_pct;
    repeat (n) send_txn(random_item());
    drain();
  endtask

  initial begin
    int seen;
    seen = 0;
    rsp_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != seen) begin
        seen = hold_requests;
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        rsp_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    wait (rst === 1'b0);
    while (idle < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
      else idle++;
    end
    $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  initial begin
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests = 0;
    sent          = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    directed(FUNC_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
    directed(FUNC_SUB, 32'd1, 32'd2, 32'd1, 32'd2);
    directed(FUNC_MUL, -32'sd2, 32'd4, 32'd3, -32'sd6);
    directed(FUNC_DIV, 32'd1, 32'd2, 32'd0, 32'd5);
    directed(FUNC_DIV, 32'd3, 32'd4, 32'd3, 32'd4);
    directed(FUNC_RED, 32'd6, -32'sd4, 32'd0, 32'd0);
    directed(FUNC_RED, 32'd0, 32'd0, 32'd1, 32'd1);
    directed(FUNC_RED, MINN, '1, 32'd2, 32'd3);
    directed(FUNC_RED, MINN, 32'd1, MAXP, MINN);
    directed(FUNC_MUL, MINN, 32'd1, MINN, 32'd1);
    directed(FUNC_ADD, MAXP, 32'd1, MAXP, 32'd1);
    directed(FUNC_SUB, MINN, 32'd1, MAXP, 32'd1);
    directed(FUNC_ADD, 32'd1, 32'd0, 32'd1, 32'd1);
    directed(FUNC_DIV, MINN, MINN, MINN, MINN);
    directed(FUNC_MUL, MAXP, MINN, MINN, MAXP);
    directed(FUNC_RED, FIB46, FIB45, 32'd7, 32'd9);
    directed(FUNC_MUL, FIB46, FIB45, FIB46, FIB45);
    directed(FUNC_RSV5, 32'd10, 32'd4, 32'd1, 32'd2);
    directed(FUNC_RSV6, -32'sd9, 32'd12, 32'd5, -32'sd5);
    directed(FUNC_RSV7, 32'd0, -32'sd7, 32'd0, 32'd0);
    directed(FUNC_ADD, 32'd0, -32'sd3, 32'd0, 32'd7);
    directed(FUNC_SUB, '1, '1, '1, '1);
    directed(FUNC_DIV, -32'sd5, 32'd3, -32'sd7, -32'sd2);
    directed(FUNC_ADD, MAXP, MAXP, MINN, MINN);
    directed(FUNC_MUL, 32'd0, MINN, MAXP, 32'd0);
    drain();

    run_random(450, 0, 0);
    run_random(450, 88, 0);
    run_random(450, 0, 88);
    run_random(440, 6, 6);

    // long output hold-off while the request side keeps offering
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_requests++;
    repeat (40) send_txn(quick_item());
    drain();

    repeat (500) @(negedge clk);
    $display("Sent %0d transactions over add, sub, mul, div, reduce and reserved codes,",
             sent);
    $display("under idle, stall and hold-off phases; %0d results checked,", checked);
    $display("%0d with zero den, %0d with overflow", zero_dens, overflows);
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/rau_pkg.sv
sv/rau_div.sv
sv/rational_arith_unit.sv
sim/rational_checker.sv
sim/testbench.sv
